[sv/i8080_pkg.sv]
package i8080_pkg;

  localparam int unsigned MemAddrBits = 16;

  localparam logic [1:0] CmdExec  = 2'd0;
  localparam logic [1:0] CmdWrite = 2'd1;
  localparam logic [1:0] CmdRead  = 2'd2;
  localparam logic [1:0] CmdNone  = 2'd3;

  localparam int unsigned FlZ  = 0;
  localparam int unsigned FlS  = 1;
  localparam int unsigned FlP  = 2;
  localparam int unsigned FlC  = 3;
  localparam int unsigned FlAc = 4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  data;
  } cmd_t;

  function automatic logic [2:0] zsp(input logic [7:0] v);
    zsp = {~^v, v[7], v == 8'h00};
  endfunction

endpackage

[sv/i8080_front.sv]
module i8080_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  i8080_pkg::cmd_t     in_cmd_i,
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output i8080_pkg::cmd_t     q_cmd_o
);
  i8080_pkg::cmd_t slot_q [2];
  logic [1:0] cnt_q;
  logic       wp_q, rp_q;
  logic       push, pop;

  assign in_stall_o = cnt_q == 2'd2;
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = cnt_q != 2'd0;
  assign pop        = q_pop_i && q_valid_o;
  assign q_cmd_o    = slot_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wp_q] <= in_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

[sv/i8080_back.sv]
module i8080_back #(
  parameter int unsigned MemAddrBits = i8080_pkg::MemAddrBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  output logic             q_pop_o,
  input  i8080_pkg::cmd_t  q_cmd_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       read_data_o,
  output logic             unimplemented_o,
  output logic [15:0]      pc_now_o,
  output logic [15:0]      sp_now_o,
  output logic [7:0]       acc_now_o,
  output logic [15:0]      bc_now_o,
  output logic [15:0]      de_now_o,
  output logic [15:0]      hl_now_o,
  output logic [4:0]       flag_word_o,
  output logic             irq_enabled_o
);
  localparam logic [3:0] StIdle = 4'd0, StRd = 4'd1, StOp = 4'd2, StB1 = 4'd3,
                         StB2 = 4'd4, StExe = 4'd5, StM1 = 4'd6, StM2 = 4'd7,
                         StFin = 4'd8, StOut = 4'd9;

  logic [7:0] mem_q [2**MemAddrBits];
  logic [7:0] rdata_q;
  logic [MemAddrBits-1:0] maddr;
  logic [15:0] addr16;
  logic [7:0]  wdata;
  logic        we;

  logic [3:0]  st_q, st_d;
  logic [15:0] pc_q, pc_d, sp_q, sp_d;
  logic [7:0]  a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d, e_q, e_d, h_q, h_d, l_q, l_d;
  logic [4:0]  f_q, f_d;
  logic        ie_q, ie_d;
  logic [7:0]  op_q, op_d, b1_q, b1_d, b2_q, b2_d, rd_q, rd_d;
  logic        un_q, un_d;
  logic [7:0]  t1_q, t1_d;
  logic        out_v_q, out_v_d;

  logic [15:0] imm, hl, de, bc;
  logic [16:0] sum;
  logic [8:0]  add9;
  logic [7:0]  tmp;

  assign maddr = addr16[MemAddrBits-1:0];

  always_ff @(posedge clk_i) begin
    if (we) mem_q[maddr] <= wdata;
    rdata_q <= mem_q[maddr];
  end

  assign imm = {b2_q, b1_q};
  assign hl  = {h_q, l_q};
  assign de  = {d_q, e_q};
  assign bc  = {b_q, c_q};

  always_comb begin
    st_d = st_q; pc_d = pc_q; sp_d = sp_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; e_d = e_q; h_d = h_q; l_d = l_q;
    f_d = f_q; ie_d = ie_q; op_d = op_q; b1_d = b1_q; b2_d = b2_q;
    rd_d = rd_q; un_d = un_q; t1_d = t1_q; out_v_d = out_v_q;
    addr16 = q_cmd_i.addr; wdata = q_cmd_i.data; we = 1'b0;
    q_pop_o = 1'b0;
    sum = '0; add9 = '0; tmp = '0;
    unique case (st_q)
      StIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          rd_d = '0; un_d = 1'b0;
          unique case (q_cmd_i.cmd)
            i8080_pkg::CmdExec:  begin addr16 = pc_q; st_d = StOp; end
            i8080_pkg::CmdWrite: begin we = 1'b1; st_d = StOut; out_v_d = 1'b1; end
            i8080_pkg::CmdRead:  st_d = StRd;
            i8080_pkg::CmdNone:  begin st_d = StOut; out_v_d = 1'b1; end
            default: ;
          endcase
        end
      end
      StRd: begin rd_d = rdata_q; st_d = StOut; out_v_d = 1'b1; end
      StOp: begin op_d = rdata_q; addr16 = pc_q + 16'd1; st_d = StB1; end
      StB1: begin b1_d = rdata_q; addr16 = pc_q + 16'd2; st_d = StB2; end
      StB2: begin
        b2_d = rdata_q; st_d = StFin;
        unique case (op_q)
          8'h1a: begin addr16 = de; st_d = StM1; end
          8'h3a: begin addr16 = {rdata_q, b1_q}; st_d = StM1; end
          8'h56, 8'h5e, 8'h66, 8'h7e: begin addr16 = hl; st_d = StM1; end
          8'hc1, 8'hd1, 8'he1, 8'hf1, 8'hc9: begin addr16 = sp_q; st_d = StM1; end
          default: st_d = StExe;
        endcase
      end
      StM1: begin
        t1_d = rdata_q;
        if (op_q == 8'hc1 || op_q == 8'hd1 || op_q == 8'he1 ||
            op_q == 8'hf1 || op_q == 8'hc9) begin
          addr16 = sp_q + 16'd1; st_d = StM2;
        end else begin
          st_d = StExe;
        end
      end
      StM2: begin
        sp_d = sp_q + 16'd2; pc_d = pc_q + 16'd1; st_d = StOut; out_v_d = 1'b1;
        unique case (op_q)
          8'hc1: begin b_d = rdata_q; c_d = t1_q; end
          8'hd1: begin d_d = rdata_q; e_d = t1_q; end
          8'he1: begin h_d = rdata_q; l_d = t1_q; end
          8'hf1: begin a_d = rdata_q; f_d = t1_q[4:0]; end
          default: pc_d = {rdata_q, t1_q};
        endcase
      end
      StExe: begin
        pc_d = pc_q + 16'd1; st_d = StOut; out_v_d = 1'b1;
        unique case (op_q)
          8'h00: ;
          8'h01: begin b_d = b2_q; c_d = b1_q; pc_d = pc_q + 16'd3; end
          8'h05: begin b_d = b_q - 8'd1; f_d[2:0] = i8080_pkg::zsp(b_d); end
          8'h06: begin b_d = b1_q; pc_d = pc_q + 16'd2; end
          8'h09, 8'h19, 8'h29: begin
            sum = {1'b0, hl} + {1'b0, (op_q == 8'h09) ? bc : (op_q == 8'h19) ? de : hl};
            h_d = sum[15:8]; l_d = sum[7:0]; f_d[i8080_pkg::FlC] = sum[16];
          end
          8'h0d: begin c_d = c_q - 8'd1; f_d[2:0] = i8080_pkg::zsp(c_d); end
          8'h0e: begin c_d = b1_q; pc_d = pc_q + 16'd2; end
          8'h0f: begin a_d = {a_q[0], a_q[7:1]}; f_d[i8080_pkg::FlC] = a_q[0]; end
          8'h11: begin d_d = b2_q; e_d = b1_q; pc_d = pc_q + 16'd3; end
          8'h13: {d_d, e_d} = de + 16'd1;
          8'h1a: a_d = t1_q;
          8'h21: begin h_d = b2_q; l_d = b1_q; pc_d = pc_q + 16'd3; end
          8'h23: {h_d, l_d} = hl + 16'd1;
          8'h26: begin h_d = b1_q; pc_d = pc_q + 16'd2; end
          8'h31: begin sp_d = imm; pc_d = pc_q + 16'd3; end
          8'h32: begin addr16 = imm; wdata = a_q; we = 1'b1; pc_d = pc_q + 16'd3; end
          8'h36: begin addr16 = hl; wdata = b1_q; we = 1'b1; pc_d = pc_q + 16'd2; end
          8'h3a: begin a_d = t1_q; pc_d = pc_q + 16'd3; end
          8'h3e: begin a_d = b1_q; pc_d = pc_q + 16'd2; end
          8'h56: d_d = t1_q;
          8'h5e: e_d = t1_q;
          8'h66: h_d = t1_q;
          8'h6f: l_d = a_q;
          8'h77: begin addr16 = hl; wdata = a_q; we = 1'b1; end
          8'h7a: a_d = d_q;
          8'h7b: a_d = e_q;
          8'h7c: a_d = h_q;
          8'h7e: a_d = t1_q;
          8'ha7: f_d = {2'b00, i8080_pkg::zsp(a_q)};
          8'haf: begin a_d = '0; f_d = {2'b00, i8080_pkg::zsp(8'h00)}; end
          8'hc2: pc_d = f_q[i8080_pkg::FlZ] ? pc_q + 16'd3 : imm;
          8'hc3: pc_d = imm;
          8'hc5, 8'hd5, 8'he5, 8'hf5, 8'hcd: begin
            addr16 = sp_q - 16'd1; we = 1'b1; st_d = StM1; out_v_d = 1'b0;
            pc_d = pc_q;
            unique case (op_q)
              8'hc5: wdata = b_q;
              8'hd5: wdata = d_q;
              8'he5: wdata = h_q;
              8'hf5: wdata = a_q;
              default: wdata = sum[15:8];
            endcase
            if (op_q == 8'hcd) begin
              sum = {1'b0, pc_q} + 17'd3; wdata = sum[15:8];
            end
            st_d = StFin;
          end
          8'hc6: begin
            add9 = {1'b0, a_q} + {1'b0, b1_q}; a_d = add9[7:0];
            f_d[2:0] = i8080_pkg::zsp(add9[7:0]); f_d[i8080_pkg::FlC] = add9[8];
            pc_d = pc_q + 16'd2;
          end
          8'hd3: pc_d = pc_q + 16'd2;
          8'he6: begin
            a_d = a_q & b1_q; f_d = {2'b00, i8080_pkg::zsp(a_q & b1_q)};
            pc_d = pc_q + 16'd2;
          end
          8'heb: begin d_d = h_q; e_d = l_q; h_d = d_q; l_d = e_q; end
          8'hfb: ie_d = 1'b1;
          8'hfe: begin
            tmp = a_q - b1_q; f_d[2:0] = i8080_pkg::zsp(tmp);
            f_d[i8080_pkg::FlC] = a_q < b1_q; pc_d = pc_q + 16'd2;
          end
          default: begin un_d = 1'b1; pc_d = pc_q; end
        endcase
      end
      StFin: begin
        addr16 = sp_q - 16'd2; we = 1'b1; sp_d = sp_q - 16'd2;
        st_d = StOut; out_v_d = 1'b1; pc_d = pc_q + 16'd1;
        sum = {1'b0, pc_q} + 17'd3;
        unique case (op_q)
          8'hc5: wdata = c_q;
          8'hd5: wdata = e_q;
          8'he5: wdata = l_q;
          8'hf5: wdata = {3'b000, f_q};
          default: begin wdata = sum[7:0]; pc_d = imm; end
        endcase
      end
      StOut: begin
        if (!out_stall_i) begin out_v_d = 1'b0; st_d = StIdle; end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; pc_q <= '0; sp_q <= '0;
      a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0; e_q <= '0; h_q <= '0; l_q <= '0;
      f_q <= '0; ie_q <= 1'b0; out_v_q <= 1'b0; un_q <= 1'b0; rd_q <= '0;
    end else begin
      st_q <= st_d; pc_q <= pc_d; sp_q <= sp_d;
      a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d; e_q <= e_d; h_q <= h_d; l_q <= l_d;
      f_q <= f_d; ie_q <= ie_d; out_v_q <= out_v_d; un_q <= un_d; rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; b1_q <= b1_d; b2_q <= b2_d; t1_q <= t1_d;
  end

  assign out_valid_o     = out_v_q;
  assign read_data_o     = rd_q;
  assign unimplemented_o = un_q;
  assign pc_now_o        = pc_q;
  assign sp_now_o        = sp_q;
  assign acc_now_o       = a_q;
  assign bc_now_o        = bc;
  assign de_now_o        = de;
  assign hl_now_o        = hl;
  assign flag_word_o     = f_q;
  assign irq_enabled_o   = ie_q;
endmodule

[sv/i8080_instruction_subset_step.sv]
// 8080-style core on one single-port byte memory. A write command is done as taken; a read
// command waits in StRd for registered data. An instruction fetches opcode and two operand
// bytes one per cycle, plus a memory state for a memory operand, a stack push or a stack pop;
// results then wait in StOut while stalled. Memory has no reset; load the program before running.
module i8080_instruction_subset_step #(
  parameter int unsigned MemAddrBits = i8080_pkg::MemAddrBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] mem_address_i,
  input  logic [7:0]  mem_write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic        unimplemented_o,
  output logic [15:0] pc_now_o,
  output logic [15:0] sp_now_o,
  output logic [7:0]  acc_now_o,
  output logic [15:0] bc_now_o,
  output logic [15:0] de_now_o,
  output logic [15:0] hl_now_o,
  output logic [4:0]  flag_word_o,
  output logic        irq_enabled_o
);
  i8080_pkg::cmd_t in_cmd, q_cmd;
  logic q_valid, q_pop;

  assign in_cmd = '{cmd: opcode_i, addr: mem_address_i, data: mem_write_data_i};

  i8080_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_cmd_i(in_cmd),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_cmd_o(q_cmd)
  );

  i8080_back #(.MemAddrBits(MemAddrBits)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_cmd_i(q_cmd),
    .out_valid_o, .out_stall_i, .read_data_o, .unimplemented_o, .pc_now_o,
    .sp_now_o, .acc_now_o, .bc_now_o, .de_now_o, .hl_now_o, .flag_word_o,
    .irq_enabled_o
  );

  a_unimpl_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && unimplemented_o) |-> read_data_o == 8'h00)
    else $error("unimplemented result carries read data");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(pc_now_o))
    else $error("stalled result changed");

  a_irq_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    irq_enabled_o |=> irq_enabled_o)
    else $error("interrupt enable cleared");
endmodule
